// ===== sv/ilmq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers for the indexed linked multi-queue.
package ilmq_pkg;

  // Pool size and the widths that follow from it.
  localparam int unsigned EntryCount = 64;
  localparam int unsigned QueueCount = EntryCount + 1;
  localparam int unsigned IdW        = $clog2(EntryCount + 1);
  localparam int unsigned TidW       = $clog2(EntryCount);
  localparam int unsigned QAddrW     = $clog2(QueueCount);
  localparam int unsigned LAddrW     = $clog2(EntryCount);
  localparam int unsigned OpW        = 2;

  // The id equal to the entry count stands for null.
  localparam logic [IdW-1:0] NullId = IdW'(EntryCount);

  // Operation codes.
  localparam logic [OpW-1:0] OP_ENQ = 2'd0;
  localparam logic [OpW-1:0] OP_DEQ = 2'd1;
  localparam logic [OpW-1:0] OP_REM = 2'd2;

  // One memory row: two id fields (head/tail or next/prev).
  typedef struct packed {
    logic [IdW-1:0] a;
    logic [IdW-1:0] b;
  } pair_t;

  // Write request with one enable per field.
  typedef struct packed {
    logic           a_en;
    logic           b_en;
    logic [IdW-1:0] a;
    logic [IdW-1:0] b;
  } pair_wr_t;

  // True when the id names a real entry.
  function automatic logic id_ok(input logic [IdW-1:0] id);
    return id < NullId;
  endfunction

endpackage

// ===== sv/ilmq_pair_ram.sv =====
`timescale 1ns / 1ps
// Two-field synchronous RAM with per-field write enables and reset-valid bits.
module ilmq_pair_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output ilmq_pkg::pair_t   rd_data_o,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  ilmq_pkg::pair_wr_t wr_i
);
  import ilmq_pkg::*;

  logic [IdW-1:0]   mem_a [Depth];
  logic [IdW-1:0]   mem_b [Depth];
  logic [Depth-1:0] a_vld_q;
  logic [Depth-1:0] b_vld_q;
  pair_t            rd_q;

  // A field that was never written since reset reads as null.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= '0;
      b_vld_q <= '0;
    end else begin
      if (wr_i.a_en) begin
        a_vld_q[wr_addr_i] <= 1'b1;
      end
      if (wr_i.b_en) begin
        b_vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  // Storage array and registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_i.a_en) begin
      mem_a[wr_addr_i] <= wr_i.a;
    end
    if (wr_i.b_en) begin
      mem_b[wr_addr_i] <= wr_i.b;
    end
    if (rd_en_i) begin
      rd_q.a <= a_vld_q[rd_addr_i] ? mem_a[rd_addr_i] : NullId;
      rd_q.b <= b_vld_q[rd_addr_i] ? mem_b[rd_addr_i] : NullId;
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== sv/indexed_linked_multi_queue.sv =====
`timescale 1ns / 1ps
// Top level: multi-queue sequencer over a queue memory and a link memory.
//
// Several FIFO queues of entry ids share one pool; each queue keeps head and
// tail in the queue memory and each entry keeps next and prev in the link
// memory. An operation is taken when start is high and busy is low, then
// busy stays high while the queue row (and the link row of the given id) is
// read, while a dequeue reads the link row of the head, and while each extra
// link write is made in a state of its own, since the link memory has
// a single write port. The result appears on done_o for one cycle right after
// busy falls, and a new operation may be started in that same cycle; a new one
// is taken only after the last is done. The receiver cannot stall results.
// Both memories are ready right after reset; no clearing pass is needed.
module indexed_linked_multi_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [ilmq_pkg::OpW-1:0]    operation_i,
  input  logic [ilmq_pkg::IdW-1:0]    queue_id_i,
  input  logic [ilmq_pkg::TidW-1:0]   thread_id_i,
  output logic                        done_o,
  output logic [ilmq_pkg::IdW-1:0]    popped_id_o,
  output logic                        was_empty_o
);
  import ilmq_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_QRD  = 3'd1;
  localparam logic [2:0] S_LRD  = 3'd2;
  localparam logic [2:0] S_WN   = 3'd3;
  localparam logic [2:0] S_WP   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [OpW-1:0]    op_q, op_d;
  logic [IdW-1:0]    t_q, t_d;
  logic [QAddrW-1:0] q_q, q_d;
  logic              qok_q, qok_d, tok_q, tok_d;
  logic              nx_vld_q, nx_vld_d, pv_vld_q, pv_vld_d;
  logic [LAddrW-1:0] nx_addr_q, nx_addr_d, pv_addr_q, pv_addr_d;
  logic [IdW-1:0]    nx_val_q, nx_val_d, pv_val_q, pv_val_d;
  logic [IdW-1:0]    popped_q, popped_d;
  logic              empty_q, empty_d, done_q, done_d;

  logic              accept;
  logic              in_qok, in_tok;
  logic              leave;

  // Memory ports.
  logic              q_rd_en, l_rd_en;
  logic [QAddrW-1:0] q_rd_addr;
  logic [LAddrW-1:0] l_rd_addr, l_wr_addr;
  pair_t             q_rd, l_rd;
  pair_wr_t          q_wr, l_wr;

  // Field aliases of the read rows.
  logic [IdW-1:0]    head, tail, lnext, lprev;

  assign head  = q_rd.a;
  assign tail  = q_rd.b;
  assign lnext = l_rd.a;
  assign lprev = l_rd.b;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign in_qok = {1'b0, queue_id_i} < (IdW + 1)'(QueueCount);
  assign in_tok = {1'b0, thread_id_i} < (TidW + 1)'(EntryCount);

  // Queue memory: a = head, b = tail.
  ilmq_pair_ram #(
    .Depth (QueueCount),
    .AddrW (QAddrW)
  ) u_queue_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (q_rd_en),
    .rd_addr_i (q_rd_addr),
    .rd_data_o (q_rd),
    .wr_addr_i (q_q),
    .wr_i      (q_wr)
  );

  // Link memory: a = next, b = prev.
  ilmq_pair_ram #(
    .Depth (EntryCount),
    .AddrW (LAddrW)
  ) u_link_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (l_rd_en),
    .rd_addr_i (l_rd_addr),
    .rd_data_o (l_rd),
    .wr_addr_i (l_wr_addr),
    .wr_i      (l_wr)
  );

  // Sequencer: read the rows, write what can go at once, then drain the
  // pending single-field link writes.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    t_d       = t_q;
    q_d       = q_q;
    qok_d     = qok_q;
    tok_d     = tok_q;
    nx_vld_d  = nx_vld_q;
    nx_addr_d = nx_addr_q;
    nx_val_d  = nx_val_q;
    pv_vld_d  = pv_vld_q;
    pv_addr_d = pv_addr_q;
    pv_val_d  = pv_val_q;
    popped_d  = popped_q;
    empty_d   = empty_q;
    done_d    = 1'b0;
    leave     = 1'b0;
    q_rd_en   = 1'b0;
    q_rd_addr = in_qok ? queue_id_i : '0;
    l_rd_en   = 1'b0;
    l_rd_addr = in_tok ? thread_id_i : '0;
    q_wr      = '0;
    l_wr      = '0;
    l_wr_addr = t_q[LAddrW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d     = operation_i;
          t_d      = IdW'(thread_id_i);
          q_d      = in_qok ? queue_id_i : '0;
          qok_d    = in_qok;
          tok_d    = in_tok;
          popped_d = NullId;
          empty_d  = 1'b0;
          q_rd_en  = 1'b1;
          l_rd_en  = 1'b1;
          state_d  = S_QRD;
        end
      end

      S_QRD: begin
        nx_vld_d = 1'b0;
        pv_vld_d = 1'b0;
        leave    = 1'b1;
        case (op_q)
          OP_ENQ: begin
            if (qok_q && tok_q) begin
              q_wr.a_en = (tail == NullId);
              q_wr.a    = t_q;
              q_wr.b_en = 1'b1;
              q_wr.b    = t_q;
              l_wr.a_en = 1'b1;
              l_wr.a    = NullId;
              l_wr.b_en = 1'b1;
              l_wr.b    = tail;
              nx_vld_d  = id_ok(tail) && (tail != t_q);
              nx_addr_d = tail[LAddrW-1:0];
              nx_val_d  = t_q;
            end
          end
          OP_DEQ: begin
            if (!qok_q || head == NullId) begin
              empty_d = 1'b1;
            end else begin
              l_rd_en   = 1'b1;
              l_rd_addr = head[LAddrW-1:0];
              leave     = 1'b0;
              state_d   = S_LRD;
            end
          end
          OP_REM: begin
            if (qok_q && tok_q) begin
              if (head == t_q) begin
                // Removing the head is a pop; the link row of the id is at hand.
                q_wr.a_en = 1'b1;
                q_wr.a    = lnext;
                q_wr.b_en = (lnext == NullId);
                q_wr.b    = NullId;
                l_wr_addr = head[LAddrW-1:0];
                l_wr.a_en = 1'b1;
                l_wr.a    = NullId;
                l_wr.b_en = 1'b1;
                l_wr.b    = NullId;
                pv_vld_d  = id_ok(lnext) && (lnext != head);
                pv_addr_d = lnext[LAddrW-1:0];
                pv_val_d  = NullId;
              end else if (tail == t_q) begin
                q_wr.b_en = 1'b1;
                q_wr.b    = lprev;
                l_wr.a_en = 1'b1;
                l_wr.a    = NullId;
                l_wr.b_en = 1'b1;
                l_wr.b    = NullId;
                nx_vld_d  = id_ok(lprev) && (lprev != t_q);
                nx_addr_d = lprev[LAddrW-1:0];
                nx_val_d  = NullId;
              end else begin
                // Middle: clear the id's own links, then bridge the neighbors.
                l_wr.a_en = 1'b1;
                l_wr.a    = NullId;
                l_wr.b_en = 1'b1;
                l_wr.b    = NullId;
                nx_vld_d  = id_ok(lprev) && (lprev != t_q);
                nx_addr_d = lprev[LAddrW-1:0];
                nx_val_d  = lnext;
                pv_vld_d  = id_ok(lnext) && (lnext != t_q);
                pv_addr_d = lnext[LAddrW-1:0];
                pv_val_d  = lprev;
              end
            end
          end
          default: begin
          end
        endcase
      end

      S_LRD: begin
        // Pop the head of a non-empty queue.
        leave     = 1'b1;
        q_wr.a_en = 1'b1;
        q_wr.a    = lnext;
        q_wr.b_en = (lnext == NullId);
        q_wr.b    = NullId;
        l_wr_addr = head[LAddrW-1:0];
        l_wr.a_en = id_ok(head);
        l_wr.a    = NullId;
        l_wr.b_en = id_ok(head);
        l_wr.b    = NullId;
        nx_vld_d  = 1'b0;
        pv_vld_d  = id_ok(lnext) && (lnext != head);
        pv_addr_d = lnext[LAddrW-1:0];
        pv_val_d  = NullId;
        popped_d  = head;
        empty_d   = 1'b0;
      end

      S_WN: begin
        l_wr_addr = nx_addr_q;
        l_wr.a_en = 1'b1;
        l_wr.a    = nx_val_q;
        if (pv_vld_q) begin
          state_d = S_WP;
        end else begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end

      S_WP: begin
        l_wr_addr = pv_addr_q;
        l_wr.b_en = 1'b1;
        l_wr.b    = pv_val_q;
        state_d   = S_IDLE;
        done_d    = 1'b1;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Common exit after the read phase.
    if (leave) begin
      if (nx_vld_d) begin
        state_d = S_WN;
      end else if (pv_vld_d) begin
        state_d = S_WP;
      end else begin
        state_d = S_IDLE;
        done_d  = 1'b1;
      end
    end
  end

  // Sequencer and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_ENQ;
      t_q       <= '0;
      q_q       <= '0;
      qok_q     <= 1'b0;
      tok_q     <= 1'b0;
      nx_vld_q  <= 1'b0;
      nx_addr_q <= '0;
      nx_val_q  <= '0;
      pv_vld_q  <= 1'b0;
      pv_addr_q <= '0;
      pv_val_q  <= '0;
      popped_q  <= NullId;
      empty_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      t_q       <= t_d;
      q_q       <= q_d;
      qok_q     <= qok_d;
      tok_q     <= tok_d;
      nx_vld_q  <= nx_vld_d;
      nx_addr_q <= nx_addr_d;
      nx_val_q  <= nx_val_d;
      pv_vld_q  <= pv_vld_d;
      pv_addr_q <= pv_addr_d;
      pv_val_q  <= pv_val_d;
      popped_q  <= popped_d;
      empty_q   <= empty_d;
      done_q    <= done_d;
    end
  end

  assign done_o      = done_q;
  assign popped_id_o = popped_q;
  assign was_empty_o = empty_q;

  // A result transaction is only shown once the sequencer has gone idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while an operation is still in progress");

  // Every result follows a cycle of work.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a preceding operation");

  // An accepted operation always occupies the sequencer for the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted operation did not start");

  // An empty dequeue never reports an id.
  a_empty_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && was_empty_o) |-> (popped_id_o == NullId))
    else $error("empty result carries an id");

endmodule

// ===== test/tb_indexed_linked_multi_queue.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the indexed linked multi-queue, with its own list model.
module tb_indexed_linked_multi_queue;
  import ilmq_pkg::*;

  typedef logic [IdW-1:0] id_t;

  // Operation code with no effect on the queues.
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
  // Cycles without any transaction before the run is abandoned.
  localparam int unsigned StallLimit = 600;
  // Marks a thread that sits in no queue, as seen by the stimulus.
  localparam int NoQueue = -1;

  typedef struct {
    id_t  popped;
    logic empty;
  } pop_result_t;

  // Mirror of the heads, tails and links; predicts the result of each transaction.
  class id_queue_tracker;
    id_t         heads[QueueCount];
    id_t         tails[QueueCount];
    id_t         nxt[EntryCount];
    id_t         prv[EntryCount];
    pop_result_t pending_pops[$];
    int n_enq, n_deq, n_deq_empty, n_rem_head, n_rem_tail, n_rem_mid, n_other;
    int n_checked, n_errors;

    function new();
      foreach (heads[i]) begin
        heads[i] = NullId;
        tails[i] = NullId;
      end
      foreach (nxt[i]) begin
        nxt[i] = NullId;
        prv[i] = NullId;
      end
    endfunction

    // Link accesses outside the pool read as null and are not written.
    function id_t next_of(id_t i);
      if (i < EntryCount) return nxt[i];
      return NullId;
    endfunction

    function id_t prev_of(id_t i);
      if (i < EntryCount) return prv[i];
      return NullId;
    endfunction

    function void set_next(id_t i, id_t v);
      if (i < EntryCount) nxt[i] = v;
    endfunction

    function void set_prev(id_t i, id_t v);
      if (i < EntryCount) prv[i] = v;
    endfunction

    function id_t head_of(id_t q);
      if (q < QueueCount) return heads[q];
      return NullId;
    endfunction

    // Unlinks the head of a queue and returns it, or null when the queue is empty.
    function id_t pop_front(id_t q);
      id_t front_id;
      id_t succ_id;
      front_id = heads[q];
      if (front_id == NullId) return NullId;
      succ_id = next_of(front_id);
      if (succ_id == NullId) begin
        heads[q] = NullId;
        tails[q] = NullId;
      end else begin
        heads[q] = succ_id;
        set_prev(succ_id, NullId);
      end
      set_prev(front_id, NullId);
      set_next(front_id, NullId);
      return front_id;
    endfunction

    // Applies one accepted transaction and queues the result it must produce.
    function void note_op(logic [OpW-1:0] op, id_t q, logic [TidW-1:0] t);
      pop_result_t r;
      id_t         tid;
      id_t         last_id;
      id_t         p;
      id_t         n;
      bit          q_ok;
      r.popped = NullId;
      r.empty  = 1'b0;
      tid      = id_t'(t);
      q_ok     = (q < QueueCount) && (tid < EntryCount);
      case (op)
        OP_ENQ: begin
          n_enq++;
          if (q_ok) begin
            last_id  = tails[q];
            tails[q] = tid;
            if (last_id == NullId) begin
              heads[q] = tid;
              set_prev(tid, NullId);
            end else begin
              set_prev(tid, last_id);
              set_next(last_id, tid);
            end
            set_next(tid, NullId);
          end
        end
        OP_DEQ: begin
          n_deq++;
          if (q < QueueCount) r.popped = pop_front(q);
          if (r.popped == NullId) begin
            r.empty = 1'b1;
            n_deq_empty++;
          end
        end
        OP_REM: begin
          if (q_ok) begin
            if (heads[q] == tid) begin
              n_rem_head++;
              void'(pop_front(q));
            end else if (tails[q] == tid) begin
              n_rem_tail++;
              p        = prev_of(tid);
              tails[q] = p;
              set_next(p, NullId);
              set_next(tid, NullId);
              set_prev(tid, NullId);
            end else begin
              n_rem_mid++;
              p = prev_of(tid);
              n = next_of(tid);
              set_next(p, n);
              set_prev(n, p);
              set_next(tid, NullId);
              set_prev(tid, NullId);
            end
          end else begin
            n_other++;
          end
        end
        default: n_other++;
      endcase
      pending_pops.push_back(r);
    endfunction

    // Compares one result with the oldest expectation.
    function void check_result(id_t popped, logic empty);
      pop_result_t r;
      if (pending_pops.size() == 0) begin
        $error("Result with no transaction waiting: popped_id %0d, was_empty %0d",
               popped, empty);
        n_errors++;
        return;
      end
      r = pending_pops.pop_front();
      n_checked++;
      if (popped !== r.popped) begin
        $error("popped_id mismatch: expected %0d, actual %0d", r.popped, popped);
        n_errors++;
      end
      if (empty !== r.empty) begin
        $error("was_empty mismatch: expected %0d, actual %0d", r.empty, empty);
        n_errors++;
      end
    endfunction

    function int pending();
      return pending_pops.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  logic [OpW-1:0]     operation_i = OP_ENQ;
  id_t                queue_id_i  = '0;
  logic [TidW-1:0]    thread_id_i = '0;
  logic               done_o;
  id_t                popped_id_o;
  logic               was_empty_o;

  id_queue_tracker    sb;
  int                 owner[EntryCount];
  int                 n_items;
  int unsigned        idle_cycles;

  indexed_linked_multi_queue u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation_i),
    .queue_id_i  (queue_id_i),
    .thread_id_i (thread_id_i),
    .done_o      (done_o),
    .popped_id_o (popped_id_o),
    .was_empty_o (was_empty_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Returns a random thread that is queued (or free), or NoQueue if there is none.
  function automatic int pick_thread(bit queued);
    int cnt;
    int k;
    cnt = 0;
    foreach (owner[i]) if ((owner[i] != NoQueue) == queued) cnt++;
    if (cnt == 0) return NoQueue;
    k = $urandom_range(0, cnt - 1);
    foreach (owner[i]) begin
      if ((owner[i] != NoQueue) == queued) begin
        if (k == 0) return i;
        k--;
      end
    end
    return NoQueue;
  endfunction

  // Presents one transaction, waits until it is taken, then sometimes idles for a while.
  task automatic run_op(input logic [OpW-1:0] op, input int q, input int t);
    int gap;
    operation_i <= op;
    queue_id_i  <= id_t'(q);
    thread_id_i <= t[TidW-1:0];
    start       <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_op(op, id_t'(q), t[TidW-1:0]);
    n_items++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Well-formed operations that also keep the stimulus view of queue membership.
  task automatic enqueue(input int q, input int t);
    owner[t] = q;
    run_op(OP_ENQ, q, t);
  endtask

  task automatic dequeue(input int q);
    id_t h;
    h = sb.head_of(id_t'(q));
    if (h != NullId) owner[h] = NoQueue;
    run_op(OP_DEQ, q, $urandom_range(0, EntryCount - 1));
  endtask

  task automatic remove(input int t);
    int q;
    q        = owner[t];
    owner[t] = NoQueue;
    run_op(OP_REM, q, t);
  endtask

  // Results are checked at the edge that ends their strobe cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(popped_id_o, was_empty_o);
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int r;
    int t;
    int q;
    sb          = new();
    idle_cycles = 0;
    n_items     = 0;
    foreach (owner[i]) owner[i] = NoQueue;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part: empty and out-of-range queues, removal at every position,
    // the extra queue, the unused operation code and the id extremes.
    dequeue(0);
    run_op(OP_DEQ, 127, 0);
    enqueue(0, 0);
    enqueue(0, EntryCount - 1);
    enqueue(0, 21);
    enqueue(0, 42);
    remove(21);
    remove(42);
    remove(0);
    dequeue(0);
    dequeue(0);
    enqueue(QueueCount - 1, 5);
    enqueue(QueueCount - 1, 10);
    dequeue(QueueCount - 1);
    run_op(OP_ENQ, 127, 7);
    run_op(OP_REM, 100, 10);
    run_op(OP_UNUSED, QueueCount - 1, 10);
    // This dequeue pops thread 10 while presenting an unrelated thread id.
    owner[10] = NoQueue;
    run_op(OP_DEQ, QueueCount - 1, EntryCount - 1);
    enqueue(1, 33);
    remove(33);
    dequeue(1);

    // Random part: well-formed traffic over a few busy queues, with some noise.
    repeat (470) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        if ($urandom_range(0, 1) == 0)
          run_op(OP_UNUSED, $urandom_range(0, 127), $urandom_range(0, EntryCount - 1));
        else
          run_op(OpW'($urandom_range(0, 2)), $urandom_range(QueueCount, 127),
                 $urandom_range(0, EntryCount - 1));
      end else begin
        t = pick_thread(1'b0);
        if (t != NoQueue && (pick_thread(1'b1) == NoQueue || r < 50)) begin
          q = $urandom_range(0, 9);
          if (q < 6)      q = $urandom_range(0, 3);
          else if (q < 8) q = QueueCount - 1;
          else            q = $urandom_range(0, QueueCount - 1);
          enqueue(q, t);
        end else if (r < 72) begin
          t = pick_thread(1'b1);
          if (t == NoQueue || $urandom_range(0, 3) == 0)
            q = $urandom_range(0, QueueCount - 1);
          else
            q = owner[t];
          dequeue(q);
        end else begin
          remove(pick_thread(1'b1));
        end
      end
    end

    // Broken sequences: duplicate enqueues and removals from the wrong queue.
    repeat (70) begin
      q = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 3);
      run_op(OpW'($urandom_range(0, 3)), q, $urandom_range(0, EntryCount - 1));
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d transactions: %0d enqueues, %0d dequeues (%0d on empty queues), %0d other.",
             n_items, sb.n_enq, sb.n_deq, sb.n_deq_empty, sb.n_other);
    $display("Removals at head %0d, tail %0d, middle %0d; %0d results checked.",
             sb.n_rem_head, sb.n_rem_tail, sb.n_rem_mid, sb.n_checked);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
